@@ hdl/uart_framed_fsk_audio_modulator_defines.svh @@
// ----------------------------------------------------------------------------
// uart framed fsk modulator assertion macros
// shared concurrent assertion forms, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef UART_FRAMED_FSK_AUDIO_MODULATOR_DEFINES_SVH
`define UART_FRAMED_FSK_AUDIO_MODULATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define UFM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ufm assertion failed: same-cycle implication");
// next-cycle implication
`define UFM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ufm assertion failed: next-cycle implication");
`else
`define UFM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define UFM_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hdl/ufm_pkg.sv @@
// ----------------------------------------------------------------------------
// ufm_pkg
// shared constants, types and the fsk waveform table
// ----------------------------------------------------------------------------
`default_nettype none
package ufm_pkg;

  localparam int BUF_DEPTH_DEF = 128;
  localparam int DAC_W         = 16;
  localparam int WAVE_W        = 10;
  localparam int WAVE_SHIFT    = 6;

  localparam logic [3:0] BIT_START = 4'd0;
  localparam logic [3:0] BIT_STOP  = 4'd9;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  // buffer head as seen by the framer
  typedef struct packed {
    logic       empty;
    logic       full;
    logic [7:0] data;
  } ufm_head_t;

  function automatic logic [WAVE_W-1:0] wave_lookup(input logic bit_val,
                                                    input logic phase,
                                                    input logic [1:0] sample);
    logic [WAVE_W-1:0] v;
    v = 10'd512;
    case ({bit_val, phase, sample})
      4'b0000: v = 10'd512;
      4'b0001: v = 10'd1023;
      4'b0010: v = 10'd512;
      4'b0011: v = 10'd1;
      4'b0100: v = 10'd512;
      4'b0101: v = 10'd1;
      4'b0110: v = 10'd512;
      4'b0111: v = 10'd1023;
      4'b1000: v = 10'd512;
      4'b1001: v = 10'd874;
      4'b1010: v = 10'd1023;
      4'b1011: v = 10'd874;
      4'b1100: v = 10'd512;
      4'b1101: v = 10'd150;
      4'b1110: v = 10'd1;
      4'b1111: v = 10'd150;
      default: v = 10'd512;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ hdl/ufm_if.sv @@
// ----------------------------------------------------------------------------
// ufm channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
`default_nettype none
interface ufm_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] push_byte;
  modport source (output valid, output opcode, output push_byte, input ready);
  modport sink   (input valid, input opcode, input push_byte, output ready);
endinterface

interface ufm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] dac_word;
  logic        overrun;
  modport source (output valid, output dac_word, output overrun, input ready);
  modport sink   (input valid, input dac_word, input overrun, output ready);
endinterface
`default_nettype wire

@@ hdl/ufm_buffer.sv @@
// ----------------------------------------------------------------------------
// ufm_buffer
// ring buffer memory with pointers and a registered head read
// ----------------------------------------------------------------------------
`default_nettype none
module ufm_buffer
  import ufm_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire logic [7:0] push_data,
  input  wire logic       pop,
  output ufm_head_t       head
);

  localparam int PTR_W = $clog2(BUF_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUF_DEPTH - 1);

  logic [7:0]       mem [BUF_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_adv, rd_adv;
  logic [7:0]       rd_data_r;
  logic             full, empty, wr_en;

  assign wr_adv = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_adv = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
  assign full   = (wr_adv == rd_ptr_r);
  assign empty  = (wr_ptr_r == rd_ptr_r);
  assign wr_en  = push && !full;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_adv : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_adv : rd_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // head entry is read from the next read pointer and registered; a write to it is forwarded
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= push_data;
    end
    if (wr_en && (wr_ptr_r == rd_ptr_nxt)) begin
      rd_data_r <= push_data;
    end else begin
      rd_data_r <= mem[rd_ptr_nxt];
    end
  end

  assign head.empty = empty;
  assign head.full  = full;
  assign head.data  = rd_data_r;

endmodule
`default_nettype wire

@@ hdl/ufm_framer.sv @@
// ----------------------------------------------------------------------------
// ufm_framer
// uart bit sequencer and fsk waveform lookup, one step per sample tick
// ----------------------------------------------------------------------------
`default_nettype none
module ufm_framer
  import ufm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             tick,
  input  wire ufm_head_t        head,
  output logic                  pop,
  output logic [DAC_W-1:0]      dac_word
);

  logic [7:0] shift_r, shift_nxt;
  logic [3:0] bitpos_r, bitpos_nxt;
  logic [1:0] sample_r, sample_nxt;
  logic       phase_r, phase_nxt;
  logic       cur_r, cur_nxt;
  logic [WAVE_W-1:0] wave;

  assign wave     = wave_lookup(cur_r, phase_r, sample_r);
  assign dac_word = {wave, {WAVE_SHIFT{1'b0}}};

  always_comb begin
    shift_nxt  = shift_r;
    bitpos_nxt = bitpos_r;
    sample_nxt = sample_r;
    phase_nxt  = phase_r;
    cur_nxt    = cur_r;
    pop        = 1'b0;
    if (tick) begin
      sample_nxt = sample_r + 2'd1;
      if (sample_r == 2'd3) begin
        phase_nxt = phase_r ^ cur_r;
        if (bitpos_r == BIT_START) begin
          cur_nxt    = 1'b0;
          bitpos_nxt = bitpos_r + 4'd1;
        end else if (bitpos_r == BIT_STOP) begin
          cur_nxt = 1'b1;
          // stop bit repeats until a byte is waiting
          if (!head.empty) begin
            pop        = 1'b1;
            shift_nxt  = head.data;
            bitpos_nxt = BIT_START;
          end
        end else begin
          cur_nxt    = shift_r[0];
          shift_nxt  = {1'b0, shift_r[7:1]};
          bitpos_nxt = bitpos_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= '0;
      bitpos_r <= BIT_START;
      sample_r <= '0;
      phase_r  <= 1'b0;
      cur_r    <= 1'b0;
    end else begin
      shift_r  <= shift_nxt;
      bitpos_r <= bitpos_nxt;
      sample_r <= sample_nxt;
      phase_r  <= phase_nxt;
      cur_r    <= cur_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/uart_framed_fsk_audio_modulator.sv @@
// ----------------------------------------------------------------------------
// uart_framed_fsk_audio_modulator
// uart framed bytes sent as fsk audio samples from a ring buffer
// ----------------------------------------------------------------------------
// usage:
//   in_chan carries items: opcode push (store push_byte in the ring buffer)
//   or opcode tick (produce one dac sample). every item gives exactly one
//   result item on out_chan: dac_word and overrun.
//   a push into a full buffer (BUF_DEPTH-1 bytes held) is dropped and
//   reports overrun = 1 with dac_word = 0; a tick reports the waveform word.
//   results are registered; throughput is one item per cycle while out_chan
//   takes results. the only loop is the head read of the buffer memory,
//   which is prefetched so a frame end never waits on it.
//   reset (synchronous, active low) empties the buffer and returns the
//   framer to a start bit with a zero byte, so the first frame sends 0x00;
//   no clearing pass is needed since unwritten entries are never read.
//   when out_chan stalls, the result is held and in_chan is taken only in
//   the cycle the held result leaves.
// ----------------------------------------------------------------------------
`default_nettype none
`include "uart_framed_fsk_audio_modulator_defines.svh"
module uart_framed_fsk_audio_modulator
  import ufm_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ufm_in_if.sink    in_chan,
  ufm_out_if.source out_chan
);

  ufm_head_t          head;
  logic               pop;
  logic               accept, push, tick, in_ready;
  logic [DAC_W-1:0]   tick_word;
  logic               out_valid_r, out_valid_nxt;
  logic [DAC_W-1:0]   out_dac_r;
  logic               out_ovr_r;

  assign in_ready      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = in_ready;
  assign accept        = in_chan.valid && in_ready;
  assign push          = accept && (in_chan.opcode == OP_PUSH);
  assign tick          = accept && (in_chan.opcode == OP_TICK);

  ufm_buffer #(.BUF_DEPTH(BUF_DEPTH)) u_buffer (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (in_chan.push_byte),
    .pop       (pop),
    .head      (head)
  );

  ufm_framer u_framer (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick     (tick),
    .head     (head),
    .pop      (pop),
    .dac_word (tick_word)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_dac_r <= tick ? tick_word : '0;
      out_ovr_r <= push && head.full;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.dac_word = out_dac_r;
  assign out_chan.overrun  = out_ovr_r;

  `UFM_ASSERT_IMP(a_pop_needs_data, clk, rst_n, pop, !head.empty)
  `UFM_ASSERT_NXT(a_push_fills, clk, rst_n, push && !head.full, !head.empty)
  `UFM_ASSERT_IMP(a_overrun_silent, clk, rst_n, out_valid_r && out_ovr_r, out_dac_r == '0)
  `UFM_ASSERT_NXT(a_accept_gives_result, clk, rst_n, accept, out_valid_r)

endmodule
`default_nettype wire
